FILE: hdl/dcax_pkg.sv
// ----------------------------------------------------------------------------
// dcax_pkg
// Shared types and constants for the DCT coefficient amplitude XOR block.
// ----------------------------------------------------------------------------
`default_nettype none

package dcax_pkg;

  // Field widths
  localparam int unsigned CoefW    = 12;
  localparam int unsigned PosW     = 6;
  localparam int unsigned CompW    = 2;
  localparam int unsigned KeyW     = 12;
  localparam int unsigned UsedW    = 4;
  localparam int unsigned AmpW     = CoefW - 1;   // largest category is 11
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgDcEnable     = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgAcEnable     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgLumaEnable   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgChromaEnable = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgNumComp      = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgRecoverMode  = 3'd5;

  // Reset value for the component count
  localparam logic [CompW-1:0] NumCompReset = 2'd3;

  typedef struct packed {
    logic             dc_enable;
    logic             ac_enable;
    logic             luma_enable;
    logic             chroma_enable;
    logic [CompW-1:0] comp_count;
    logic             recover_mode;
  } cfg_t;

  typedef struct packed {
    logic [KeyW-1:0]  key_bits;
    logic [CompW-1:0] component;
    logic [PosW-1:0]  position;
    logic [CoefW-1:0] coefficient;
  } in_item_t;

  typedef struct packed {
    logic [UsedW-1:0] key_bits_used;
    logic             changed;
    logic [CoefW-1:0] coefficient_out;
  } out_item_t;

  localparam int unsigned InDataW  = $bits(in_item_t);           // 32
  localparam int unsigned OutBits  = $bits(out_item_t);          // 17
  localparam int unsigned OutDataW = ((OutBits + 7) / 8) * 8;    // 24

endpackage

`default_nettype wire

FILE: hdl/dcax_cfg.sv
// ----------------------------------------------------------------------------
// dcax_cfg
// Configuration register file: enables, component count and recover mode.
// ----------------------------------------------------------------------------
`default_nettype none

module dcax_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          wr_en_i,
  input  wire logic [dcax_pkg::CfgIdxW-1:0]  wr_index_i,
  input  wire logic [dcax_pkg::CfgDataW-1:0] wr_data_i,
  output dcax_pkg::cfg_t                     cfg_o
);

  dcax_pkg::cfg_t cfg_q, cfg_d;

  // Decode register writes; unknown indexes are ignored
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        dcax_pkg::CfgDcEnable:     cfg_d.dc_enable     = wr_data_i[0];
        dcax_pkg::CfgAcEnable:     cfg_d.ac_enable     = wr_data_i[0];
        dcax_pkg::CfgLumaEnable:   cfg_d.luma_enable   = wr_data_i[0];
        dcax_pkg::CfgChromaEnable: cfg_d.chroma_enable = wr_data_i[0];
        dcax_pkg::CfgNumComp:      cfg_d.comp_count    = wr_data_i;
        dcax_pkg::CfgRecoverMode:  cfg_d.recover_mode  = wr_data_i[0];
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dc_enable     <= 1'b1;
      cfg_q.ac_enable     <= 1'b1;
      cfg_q.luma_enable   <= 1'b1;
      cfg_q.chroma_enable <= 1'b1;
      cfg_q.comp_count    <= dcax_pkg::NumCompReset;
      cfg_q.recover_mode  <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: hdl/dcax_xor.sv
// ----------------------------------------------------------------------------
// dcax_xor
// Per-coefficient datapath: selection, magnitude category, amplitude XOR
// and mapping back to a signed value.
// ----------------------------------------------------------------------------
`default_nettype none

module dcax_xor (
  input  wire dcax_pkg::in_item_t item_i,
  input  wire dcax_pkg::cfg_t     cfg_i,
  output dcax_pkg::out_item_t     res_o
);

  localparam int unsigned CoefW = dcax_pkg::CoefW;
  localparam int unsigned AmpW  = dcax_pkg::AmpW;

  logic             neg;
  logic [CoefW-1:0] mag;
  logic             pos_ok, comp_ok, mag_ok, apply;
  logic [3:0]       cat;
  logic [3:0]       top_idx;
  logic [CoefW-1:0] mask_w;
  logic [AmpW-1:0]  mask, amp, key_sel, bits;
  logic [CoefW-1:0] ciphered;
  logic [CoefW-1:0] comp_end;

  // Sign and magnitude
  assign neg = item_i.coefficient[CoefW-1];
  assign mag = neg ? (CoefW'(0) - item_i.coefficient) : item_i.coefficient;

  // Position and component selection
  assign pos_ok   = (cfg_i.dc_enable || (item_i.position != '0)) &&
                    (cfg_i.ac_enable || (item_i.position == '0));
  assign comp_end = cfg_i.chroma_enable ? CoefW'(cfg_i.comp_count) : CoefW'(1);
  assign comp_ok  = (cfg_i.luma_enable || (item_i.component != '0)) &&
                    (CoefW'(item_i.component) < comp_end);

  // Zero and -2048 pass through; +/-1 passes through in encrypt mode
  assign mag_ok = (mag != '0) && !mag[CoefW-1] &&
                  (cfg_i.recover_mode || (mag != CoefW'(1)));
  assign apply  = pos_ok && comp_ok && mag_ok;

  // Magnitude category: index of highest set bit plus one
  always_comb begin
    cat = 4'd1;
    for (int i = 1; i < AmpW; i++) begin
      if (mag[i]) cat = 4'(i + 1);
    end
  end

  assign mask_w  = (CoefW'(1) << cat) - CoefW'(1);
  assign mask    = mask_w[AmpW-1:0];
  assign amp     = neg ? (mag[AmpW-1:0] ^ mask) : mag[AmpW-1:0];
  // Recover mode skips the first key bit
  assign key_sel = cfg_i.recover_mode ? item_i.key_bits[AmpW:1] : item_i.key_bits[AmpW-1:0];
  assign bits    = (key_sel ^ amp) & mask;
  assign top_idx = cat - 4'd1;

  // JPEG amplitude decode: top bit set is positive, clear is negative
  assign ciphered = bits[top_idx] ? {1'b0, bits}
                                  : (CoefW'(0) - {1'b0, (bits ^ mask)});

  always_comb begin
    res_o.coefficient_out = item_i.coefficient;
    res_o.changed         = 1'b0;
    res_o.key_bits_used   = '0;
    if (apply) begin
      res_o.coefficient_out = ciphered;
      res_o.changed         = 1'b1;
      res_o.key_bits_used   = cat + {3'b000, cfg_i.recover_mode};
    end
  end

endmodule

`default_nettype wire

FILE: hdl/dct_coefficient_amplitude_xor.sv
// ----------------------------------------------------------------------------
// dct_coefficient_amplitude_xor
// Top level: input register, amplitude XOR datapath, result register.
// ----------------------------------------------------------------------------
// One coefficient is accepted per clock. The item is captured in an input
// register, the category/XOR logic runs between that register and the result
// register, and the result is offered on the master side once it is loaded
// into the result register and held there until the master side takes it.
// Throughput is one item per cycle; both stages stall in place under
// backpressure and the input stage keeps accepting while a result waits,
// as long as it is empty. Configuration writes take effect on the next
// cycle and must only be issued while no transaction is in flight.
`default_nettype none

module dct_coefficient_amplitude_xor (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Configuration write channel
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [dcax_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [dcax_pkg::CfgDataW-1:0]  cfg_data_i,
  // Input stream
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // [11:0] coefficient, [17:12] position, [19:18] component, [31:20] key_bits
  input  wire logic [dcax_pkg::InDataW-1:0]   s_axis_tdata,
  // Output stream
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [11:0] coefficient_out, [12] changed, [16:13] key_bits_used, [23:17] zero
  output logic [dcax_pkg::OutDataW-1:0]       m_axis_tdata
);

  dcax_pkg::cfg_t      cfg;
  dcax_pkg::in_item_t  in_q;
  dcax_pkg::out_item_t res, out_q;
  logic                in_vld_q, out_vld_q;
  logic                in_ready, out_load;

  // Config registers; writes are always taken
  assign cfg_ready_o = 1'b1;

  dcax_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Stage handshake
  assign out_load = in_vld_q && (!out_vld_q || m_axis_tready);
  assign in_ready = !in_vld_q || out_load;
  assign s_axis_tready = in_ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && s_axis_tvalid) begin
      in_q <= dcax_pkg::in_item_t'(s_axis_tdata);
    end
  end

  dcax_xor u_xor (
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(dcax_pkg::OutDataW - dcax_pkg::OutBits){1'b0}}, out_q};

  // A stalled input item stays put until it moves to the result register
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !out_load) |=> (in_vld_q && $stable(in_q)))
    else $error("input stage item lost while stalled");

  // Changed results always report consumed key bits, skipped ones none
  a_used_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.changed) |->
      (out_q.key_bits_used != '0 && out_q.key_bits_used <= 4'd12))
    else $error("changed result with bad key bit count");

  a_used_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_q.changed) |-> (out_q.key_bits_used == '0))
    else $error("skipped result reports key bits");

  // A result load must leave the result register marked valid
  a_load_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_vld_q)
    else $error("result register load dropped");

endmodule

`default_nettype wire
